[rtl/sliding_window_anagram_search_assert.svh]
// Assertion macros shared by the block. Each expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_ANAGRAM_SEARCH_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swas_pkg.sv]
package swas_pkg;

  localparam int SYMBOL_W = 5;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic is_text;
    logic upd;
    logic retire;
    logic full;
    logic ovf;
    logic last;
  } swas_ctl_t;

  localparam int CTL_W = $bits(swas_ctl_t);

endpackage

[rtl/swas_if.sv]
interface swas_in_if;
  import swas_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source(output valid, output req_type, output symbol, output last, input ready);
  modport sink(input valid, input req_type, input symbol, input last, output ready);
endinterface

interface swas_out_if;
  logic valid;
  logic ready;
  logic window_match;
  logic found;
  logic pattern_too_long;
  logic end_of_job;

  modport source(output valid, output window_match, output found,
                 output pattern_too_long, output end_of_job, input ready);
  modport sink(input valid, input window_match, input found,
               input pattern_too_long, input end_of_job, output ready);
endinterface

[rtl/swas_front.sv]
module swas_front #(
  parameter int MAX_PATTERN = 1024,
  parameter int ALPHABET_SIZE = 26,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1),
  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int BIN_W = $clog2(ALPHABET_SIZE + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  swas_in_if.sink             in_chan,
  input  logic                q_ready,
  output logic                push,
  output swas_pkg::swas_ctl_t push_ctl,
  output logic [BIN_W-1:0]    push_bin,
  output logic [PTR_W-1:0]    push_ptr
);
  import swas_pkg::*;

  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             text_active_r, text_active_nxt;
  logic             ovf_r, ovf_nxt;

  logic             accept;
  logic             is_text;
  logic             sym_in_range;
  logic [BIN_W-1:0] bin;
  logic             plen_zero;
  logic             plen_full;
  logic             retire;
  logic [LEN_W-1:0] seen_step;
  logic [LEN_W-1:0] ptr_inc;
  logic [PTR_W-1:0] ptr_step;

  assign in_chan.ready = q_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_text       = (in_chan.req_type == REQ_TEXT);
  assign sym_in_range  = (int'(in_chan.symbol) < ALPHABET_SIZE);
  assign bin           = sym_in_range ? BIN_W'(in_chan.symbol) : BIN_W'(ALPHABET_SIZE);
  assign plen_zero     = (plen_r == '0);
  assign plen_full     = (plen_r == LEN_W'(MAX_PATTERN));
  assign retire        = !plen_zero && (seen_r == plen_r);
  assign seen_step     = (plen_zero || retire) ? seen_r : seen_r + 1'b1;
  assign ptr_inc       = LEN_W'(ptr_r) + 1'b1;
  assign ptr_step      = (ptr_inc >= plen_r) ? '0 : PTR_W'(ptr_inc);

  assign push_bin         = bin;
  assign push_ptr         = ptr_r;
  assign push_ctl.is_text = is_text;
  assign push_ctl.upd     = !plen_zero;
  assign push_ctl.retire  = retire;
  assign push_ctl.full    = (seen_step == plen_r);
  assign push_ctl.ovf     = ovf_r;
  assign push_ctl.last    = is_text && in_chan.last;

  always_comb begin
    plen_nxt        = plen_r;
    seen_nxt        = seen_r;
    ptr_nxt         = ptr_r;
    text_active_nxt = text_active_r;
    ovf_nxt         = ovf_r;
    push            = 1'b0;
    if (accept) begin
      if (is_text) begin
        push            = 1'b1;
        text_active_nxt = 1'b1;
        if (!plen_zero) begin
          seen_nxt = seen_step;
          ptr_nxt  = ptr_step;
        end
        if (in_chan.last) begin
          plen_nxt        = '0;
          seen_nxt        = '0;
          ptr_nxt         = '0;
          text_active_nxt = 1'b0;
          ovf_nxt         = 1'b0;
        end
      end else if (!text_active_r && sym_in_range) begin
        if (plen_full) begin
          ovf_nxt = 1'b1;
        end else begin
          plen_nxt = plen_r + 1'b1;
          push     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r        <= '0;
      seen_r        <= '0;
      ptr_r         <= '0;
      text_active_r <= 1'b0;
      ovf_r         <= 1'b0;
    end else begin
      plen_r        <= plen_nxt;
      seen_r        <= seen_nxt;
      ptr_r         <= ptr_nxt;
      text_active_r <= text_active_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

endmodule

[rtl/swas_queue.sv]
module swas_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              not_full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);
  import swas_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [IDX_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign not_full   = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/swas_back.sv]
`include "sliding_window_anagram_search_assert.svh"

module swas_back #(
  parameter int MAX_PATTERN = 1024,
  parameter int ALPHABET_SIZE = 26,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1),
  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int BIN_W = $clog2(ALPHABET_SIZE + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  swas_pkg::swas_ctl_t q_ctl,
  input  logic [BIN_W-1:0]    q_bin,
  input  logic [PTR_W-1:0]    q_ptr,
  output logic                q_pop,
  swas_out_if.source          out_chan
);
  import swas_pkg::*;

  localparam int NUM_BINS = ALPHABET_SIZE + 1;

  logic [BIN_W-1:0] hist_r [MAX_PATTERN];
  logic [BIN_W-1:0] old_bin_r;
  logic [BIN_W-1:0] b_bin_r;
  swas_ctl_t        b_ctl_r;
  logic             b_valid_r, b_valid_nxt;

  logic [LEN_W-1:0] pc_r [NUM_BINS];
  logic [LEN_W-1:0] wc_r [NUM_BINS];
  logic [LEN_W-1:0] pc_nxt [NUM_BINS];
  logic [LEN_W-1:0] wc_nxt [NUM_BINS];
  logic [NUM_BINS-1:0] inc_hit;
  logic [NUM_BINS-1:0] dec_hit;
  logic [NUM_BINS-1:0] pat_hit;
  logic [NUM_BINS-1:0] eq_nxt;

  logic match_seen_r, match_seen_nxt;
  logic out_valid_r, out_valid_nxt;
  logic wm_r, found_r, ovf_r, eoj_r;

  logic b_fire;
  logic b_text_fire;
  logic job_end;
  logic wm;
  logic found_now;

  assign b_fire      = b_valid_r && (!b_ctl_r.is_text || !out_valid_r || out_chan.ready);
  assign b_text_fire = b_fire && b_ctl_r.is_text;
  assign job_end     = b_ctl_r.is_text && b_ctl_r.last;
  assign q_pop       = q_valid && (!b_valid_r || b_fire);

  // The slot read here holds the symbol that leaves the window; the new symbol
  // takes its place in the same cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      old_bin_r <= hist_r[q_ptr];
      b_bin_r   <= q_bin;
      b_ctl_r   <= q_ctl;
      if (q_ctl.is_text && q_ctl.upd) begin
        hist_r[q_ptr] <= q_bin;
      end
    end
  end

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_bin
    assign inc_hit[i] = b_ctl_r.is_text && b_ctl_r.upd && (b_bin_r == BIN_W'(i));
    assign dec_hit[i] = b_ctl_r.is_text && b_ctl_r.upd && b_ctl_r.retire &&
                        (old_bin_r == BIN_W'(i));
    assign pat_hit[i] = !b_ctl_r.is_text && (b_bin_r == BIN_W'(i));
    assign wc_nxt[i]  = wc_r[i] + LEN_W'(inc_hit[i]) - LEN_W'(dec_hit[i]);
    assign pc_nxt[i]  = pc_r[i] + LEN_W'(pat_hit[i]);
    assign eq_nxt[i]  = (pc_nxt[i] == wc_nxt[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pc_r[i] <= '0;
        wc_r[i] <= '0;
      end else if (b_fire) begin
        if (job_end) begin
          pc_r[i] <= '0;
          wc_r[i] <= '0;
        end else begin
          pc_r[i] <= pc_nxt[i];
          wc_r[i] <= wc_nxt[i];
        end
      end
    end
  end

  assign wm        = b_ctl_r.full && (&eq_nxt);
  assign found_now = match_seen_r || wm;

  always_comb begin
    b_valid_nxt    = b_valid_r;
    match_seen_nxt = match_seen_r;
    out_valid_nxt  = out_valid_r;
    if (q_pop) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire) begin
      b_valid_nxt = 1'b0;
    end
    if (b_text_fire) begin
      match_seen_nxt = b_ctl_r.last ? 1'b0 : found_now;
      out_valid_nxt  = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r    <= 1'b0;
      match_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      b_valid_r    <= b_valid_nxt;
      match_seen_r <= match_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_text_fire) begin
      wm_r    <= wm;
      found_r <= found_now;
      ovf_r   <= b_ctl_r.ovf;
      eoj_r   <= b_ctl_r.last;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.window_match     = wm_r;
  assign out_chan.found            = found_r;
  assign out_chan.pattern_too_long = ovf_r;
  assign out_chan.end_of_job       = eoj_r;

  `SWAS_ASSERT_NOW(a_one_retired_bin, b_fire && b_ctl_r.is_text && b_ctl_r.retire, $onehot(dec_hit), "retired symbol does not hit exactly one bin")
  `SWAS_ASSERT_NOW(a_one_inserted_bin, b_fire && b_ctl_r.is_text && b_ctl_r.upd, $onehot(inc_hit), "inserted symbol does not hit exactly one bin")
  `SWAS_ASSERT_NEXT(a_job_end_clears, b_fire && job_end, !match_seen_r && (wc_r[0] == '0) && (pc_r[0] == '0), "state not cleared at end of job")

endmodule

[rtl/sliding_window_anagram_search.sv]
// Sliding-window anagram search.
// The input channel in_chan carries words of req_type, symbol and last. Pattern
// words (req_type low) are loaded first and build the pattern histogram; text
// words then stream through a window as long as the pattern. Pattern words give
// no result. Each text word gives one result word on out_chan with
// window_match, found, pattern_too_long and end_of_job.
// A text word with last set ends the job; its result carries the final found
// verdict and all job state is cleared behind it, so the next job may follow
// in the very next cycle.
// Throughput is one word per cycle while the output is not stalled; the
// single-port window delay line is read and written once per text word. A result
// travels through the queue, the back-end stage and the result register.
// A four-word queue separates the accepting front from the counting back end;
// when the receiver holds out_chan.ready low, the result register holds, the
// queue fills, and in_chan.ready drops once the queue is full.
// Reset (rst_n low, synchronous) clears the control state; the delay line needs
// no clearing because a slot is read only after it was written in the same job.
module sliding_window_anagram_search #(
  parameter int MAX_PATTERN = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input logic        clk,
  input logic        rst_n,
  swas_in_if.sink    in_chan,
  swas_out_if.source out_chan
);
  import swas_pkg::*;

  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BIN_W = $clog2(ALPHABET_SIZE + 1);
  localparam int Q_W   = CTL_W + BIN_W + PTR_W;

  logic             push;
  swas_ctl_t        push_ctl;
  logic [BIN_W-1:0] push_bin;
  logic [PTR_W-1:0] push_ptr;
  logic             q_not_full;
  logic             q_pop;
  logic             q_valid;
  logic [Q_W-1:0]   q_data;
  swas_ctl_t        q_ctl;
  logic [BIN_W-1:0] q_bin;
  logic [PTR_W-1:0] q_ptr;

  swas_front #(
    .MAX_PATTERN  (MAX_PATTERN),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_ready (q_not_full),
    .push    (push),
    .push_ctl(push_ctl),
    .push_bin(push_bin),
    .push_ptr(push_ptr)
  );

  swas_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_bin, push_ptr}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_data (q_data)
  );

  assign {q_ctl, q_bin, q_ptr} = q_data;

  swas_back #(
    .MAX_PATTERN  (MAX_PATTERN),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ctl   (q_ctl),
    .q_bin   (q_bin),
    .q_ptr   (q_ptr),
    .q_pop   (q_pop),
    .out_chan(out_chan)
  );

endmodule
